// ===== rtl/assert_macros.svh =====
// assert_macros.svh: assertion macros used by gapped_insertion_sorter.
// No dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Implication checked on every clock, off in reset.
`define CHK_IMPL(lbl, clk, rst, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) else $error("%m: lbl");
// Next-cycle implication, off in reset.
`define CHK_NEXT(lbl, clk, rst, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) else $error("%m: lbl");
`endif

// ===== rtl/gis_pkg.sv =====
// gis_pkg: types, constants and sizing helpers for the gapped insertion sorter.
// No dependencies.
package gis_pkg;
  localparam int NUM_SLOTS     = 512;
  localparam int SLOT_W        = 9;
  localparam int VALUE_W       = 31;
  localparam int GAP_W         = 3;
  localparam int DEF_MAX_ITEMS = 64;
  localparam int DEF_MAX_GAP   = 7;
  localparam logic [GAP_W-1:0] GAP_RESET = 3'd1;

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_SEARCH, S_SHIFT_RD, S_SHIFT_WR, S_PLACE,
    S_GATHER, S_GAPFIT, S_SPREAD, S_EMIT
  } state_t;

  typedef struct packed {
    logic             we;
    logic [SLOT_W-1:0] waddr;
    logic [VALUE_W-1:0] wdata;
    logic             wvalid;
    logic [SLOT_W-1:0] raddr;
  } mem_req_t;
endpackage

// ===== rtl/gis_store.sv =====
// gis_store: slot store, 512 values with a valid bit per slot.
// Depends on gis_pkg.
module gis_store import gis_pkg::*; (
  input  logic               clk,
  input  mem_req_t           req,
  output logic [VALUE_W-1:0] rdata,
  output logic               rvalid
);
  logic [VALUE_W-1:0] vals [NUM_SLOTS];
  logic               vbit [NUM_SLOTS];

  always_ff @(posedge clk) begin
    if (req.we) begin
      vals[req.waddr] <= req.wdata;
      vbit[req.waddr] <= req.wvalid;
    end
    rdata  <= vals[req.raddr];
    rvalid <= vbit[req.raddr];
  end
endmodule

// ===== rtl/gis_queue.sv =====
// gis_queue: gather buffer used while rebalancing.
// Depends on gis_pkg.
module gis_queue import gis_pkg::*; #(
  parameter int MAX_ITEMS = DEF_MAX_ITEMS,
  localparam int QW = (MAX_ITEMS > 1) ? $clog2(MAX_ITEMS) : 1
) (
  input  logic               clk,
  input  logic               we,
  input  logic [QW-1:0]      waddr,
  input  logic [VALUE_W-1:0] wdata,
  input  logic [QW-1:0]      raddr,
  output logic [VALUE_W-1:0] rdata
);
  logic [VALUE_W-1:0] q [MAX_ITEMS];
  always_ff @(posedge clk) begin
    if (we) begin
      q[waddr] <= wdata;
    end
    rdata <= q[raddr];
  end
endmodule

// ===== rtl/gapped_insertion_sorter.sv =====
// gapped_insertion_sorter: top level, sequencer around slot store and gather queue.
// Depends on gis_pkg, gis_store, gis_queue, assert_macros.svh.
//
// channel   dir  signals                              handshake
// input     in   value, is_last                       start & !busy
// result    out  sorted_value, end_of_run             out_strobe, one cycle
// config    in   gap_slots_data                       gap_slots_we
//
// After reset a clearing pass over all 512 slots empties the slot valid bits;
// busy stays high meanwhile. An insert reads and then checks each search probe
// (about 10 bisection steps plus one probe per empty slot stepped over), then
// reads and writes each slot of the shifted run including the hole, then places;
// each rebalance gathers all 512 slots and spreads the n values back; output
// of a set sweeps all 512 slots and clears them. The single read port paces all this.
`include "assert_macros.svh"
module gapped_insertion_sorter import gis_pkg::*; #(
  parameter int MAX_ITEMS = DEF_MAX_ITEMS,
  parameter int MAX_GAP   = DEF_MAX_GAP
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic [VALUE_W-1:0] value,
  input  logic               is_last,
  input  logic               gap_slots_we,
  input  logic [GAP_W-1:0]   gap_slots_data,
  output logic               out_strobe,
  output logic [VALUE_W-1:0] sorted_value,
  output logic               end_of_run
);
  localparam int QW = (MAX_ITEMS > 1) ? $clog2(MAX_ITEMS) : 1;
  localparam int CW = $clog2(MAX_ITEMS + 1);
  localparam int GW = 4;

  state_t state, state_next;

  logic [GAP_W-1:0]   gap_slots;
  logic [VALUE_W-1:0] val;
  logic               last;
  logic [CW-1:0]      items_stored;
  logic [6:0]         next_reb;
  logic [SLOT_W-1:0]  highest;
  // search bounds over slots 0..highest, t = first slot past values <= val
  logic [SLOT_W:0]    lo, hi;
  logic [SLOT_W:0]    probe;     // scan position right of mid over empty slots
  logic               scan;      // probe in use instead of mid
  logic [SLOT_W:0]    probe_addr;
  logic [SLOT_W:0]    ptr;       // general slot pointer
  logic               phase;     // read/check sub-step
  logic [VALUE_W-1:0] carry;
  logic [CW-1:0]      n;         // gathered count
  logic [CW-1:0]      k;
  logic [GW-1:0]      g;
  logic [SLOT_W+GW:0] pos;       // spread position
  logic [SLOT_W+GW+CW:0] need;   // fit test for the current g

  mem_req_t           req;
  logic [VALUE_W-1:0] rdata;
  logic               rvalid;
  logic               q_we;
  logic [QW-1:0]      q_waddr, q_raddr;
  logic [VALUE_W-1:0] q_rdata;
  logic [SLOT_W:0]    mid;
  logic               reb_now;

  gis_store u_store (.clk(clk), .req(req), .rdata(rdata), .rvalid(rvalid));
  gis_queue #(.MAX_ITEMS(MAX_ITEMS)) u_queue (
    .clk(clk), .we(q_we), .waddr(q_waddr), .wdata(rdata),
    .raddr(q_raddr), .rdata(q_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      gap_slots <= GAP_RESET;
    end else if (gap_slots_we) begin
      gap_slots <= gap_slots_data;
    end
  end

  assign busy = (state != S_IDLE);
  assign mid  = (lo + hi) >> 1;
  // an empty mid is skipped by stepping right until a word or hi
  assign probe_addr = scan ? probe : mid;
  assign q_waddr = n[QW-1:0];
  assign q_raddr = k[QW-1:0];
  // insert that grows count to the doubling threshold triggers rebalance
  assign reb_now = (7'(items_stored) + 7'd1 == next_reb);
  assign need = (SLOT_W+GW+CW+1)'(n - 1'b1) * (SLOT_W+GW+CW+1)'({1'b0, g} + 1'b1) +
                (SLOT_W+GW+CW+1)'(n);

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_CLEAR;
      ptr          <= '0;
      phase        <= 1'b0;
      items_stored <= '0;
      next_reb     <= 7'd2;
      highest      <= '0;
      out_strobe   <= 1'b0;
      n            <= '0;
      k            <= '0;
    end else begin
      state      <= state_next;
      out_strobe <= 1'b0;
      unique case (state)
        S_CLEAR: begin
          ptr <= ptr + 1'b1;
          if (ptr == (SLOT_W+1)'(NUM_SLOTS - 1)) begin
            ptr          <= '0;
            items_stored <= '0;
            next_reb     <= 7'd2;
            highest      <= '0;
          end
        end
        S_IDLE: begin
          if (start) begin
            val   <= value;
            last  <= is_last;
            lo    <= '0;
            hi    <= {1'b0, highest} + 1'b1;
            phase <= 1'b0;
            scan  <= 1'b0;
          end
        end
        S_SEARCH: begin
          // phase 0 issues read of the probe, phase 1 narrows
          if (lo == hi) begin
            ptr   <= lo;
            carry <= val;
            phase <= 1'b0;
          end else if (!phase) begin
            phase <= 1'b1;
          end else begin
            phase <= 1'b0;
            if (rvalid && rdata <= val) begin
              lo   <= probe_addr + 1'b1;
              scan <= 1'b0;
            end else if (rvalid || probe_addr + 1'b1 == hi) begin
              // probe holds a value above val or is the last slot below hi; none of mid..probe is <= val
              hi   <= mid;
              scan <= 1'b0;
            end else begin
              probe <= probe_addr + 1'b1;
              scan  <= 1'b1;
            end
          end
        end
        S_SHIFT_RD: ;
        S_SHIFT_WR: begin
          if (rvalid) begin
            carry <= rdata;
            ptr   <= ptr + 1'b1;
          end
        end
        S_PLACE: begin
          if (ptr[SLOT_W-1:0] > highest) highest <= ptr[SLOT_W-1:0];
          items_stored <= items_stored + 1'b1;
          if (reb_now) begin
            ptr <= '0; n <= '0; phase <= 1'b0;
            next_reb <= (next_reb >= 7'd64) ? 7'd127 : {next_reb[5:0], 1'b0};
          end
        end
        S_GATHER: begin
          phase <= ~phase;
          if (phase) begin
            if (rvalid && n < CW'(MAX_ITEMS)) n <= n + 1'b1;
            ptr <= ptr + 1'b1;
            if (ptr == (SLOT_W+1)'(NUM_SLOTS - 1)) begin
              g <= (GW'(gap_slots) > GW'(MAX_GAP)) ? GW'(MAX_GAP) : GW'(gap_slots);
            end
          end
        end
        S_GAPFIT: begin
          // (n-1)*(g+1)+n > 511 lowers g one step per cycle
          if (g != '0 && n != '0 && need > (SLOT_W+GW+CW+1)'(NUM_SLOTS - 1)) begin
            g <= g - 1'b1;
          end else begin
            k <= '0; pos <= '0; phase <= 1'b0;
          end
        end
        S_SPREAD: begin
          phase <= ~phase;
          if (phase) begin
            k   <= k + 1'b1;
            pos <= pos + g + 1'b1;
            if (k + 1'b1 == n) begin
              highest <= pos[SLOT_W-1:0];
            end
          end
          if (n == '0) highest <= '0;
        end
        S_EMIT: begin
          phase <= ~phase;
          if (phase) begin
            ptr <= ptr + 1'b1;
            if (rvalid && k < CW'(MAX_ITEMS)) begin
              out_strobe   <= 1'b1;
              sorted_value <= rdata;
              k            <= k + 1'b1;
              end_of_run   <= (k + 1'b1 == items_stored);
            end
            if (ptr == (SLOT_W+1)'(NUM_SLOTS - 1)) ptr <= '0;
          end
        end
        default: ;
      endcase
      // output sweep starts at slot 0 with no words counted
      if (state != S_EMIT && state_next == S_EMIT) begin
        ptr   <= '0;
        phase <= 1'b0;
        k     <= '0;
      end
    end
  end

  // next state and store port
  always_comb begin
    state_next = state;
    req        = '0;
    q_we       = 1'b0;
    unique case (state)
      S_CLEAR: begin
        req.we    = 1'b1;
        req.waddr = ptr[SLOT_W-1:0];
        if (ptr == (SLOT_W+1)'(NUM_SLOTS - 1)) state_next = S_IDLE;
      end
      S_IDLE: begin
        if (start) begin
          if (items_stored < CW'(MAX_ITEMS)) state_next = S_SEARCH;
          else if (is_last) state_next = S_EMIT;
        end
      end
      S_SEARCH: begin
        req.raddr = probe_addr[SLOT_W-1:0];
        if (lo == hi) begin
          state_next = (lo[SLOT_W]) ? (last ? S_EMIT : S_IDLE) : S_SHIFT_RD;
        end
      end
      S_SHIFT_RD: begin
        req.raddr  = ptr[SLOT_W-1:0];
        state_next = S_SHIFT_WR;
      end
      S_SHIFT_WR: begin
        req.we     = 1'b1;
        req.waddr  = ptr[SLOT_W-1:0];
        req.wdata  = carry;
        req.wvalid = 1'b1;
        if (!rvalid) state_next = S_PLACE;
        else if (ptr == (SLOT_W+1)'(NUM_SLOTS - 1)) state_next = last ? S_EMIT : S_IDLE;
        else state_next = S_SHIFT_RD;
      end
      S_PLACE: begin
        if (reb_now) state_next = S_GATHER;
        else state_next = last ? S_EMIT : S_IDLE;
      end
      S_GATHER: begin
        req.raddr = ptr[SLOT_W-1:0];
        if (phase) begin
          req.we    = 1'b1;
          req.waddr = ptr[SLOT_W-1:0];
          q_we      = rvalid && n < CW'(MAX_ITEMS);
          if (ptr == (SLOT_W+1)'(NUM_SLOTS - 1)) state_next = S_GAPFIT;
        end
      end
      S_GAPFIT: begin
        if (!(g != '0 && n != '0 && need > (SLOT_W+GW+CW+1)'(NUM_SLOTS - 1)))
          state_next = S_SPREAD;
      end
      S_SPREAD: begin
        if (k == n) state_next = last ? S_EMIT : S_IDLE;
        else if (phase) begin
          req.we     = (pos < (SLOT_W+GW+1)'(NUM_SLOTS));
          req.waddr  = pos[SLOT_W-1:0];
          req.wdata  = q_rdata;
          req.wvalid = 1'b1;
        end
      end
      S_EMIT: begin
        req.raddr = ptr[SLOT_W-1:0];
        if (phase && ptr == (SLOT_W+1)'(NUM_SLOTS - 1)) state_next = S_CLEAR;
      end
      default: state_next = S_CLEAR;
    endcase
  end

  `CHK_IMPL(a_strobe_in_emit, clk, rst, out_strobe, $past(state) == S_EMIT)
  `CHK_IMPL(a_count_bound, clk, rst, 1'b1, items_stored <= CW'(MAX_ITEMS))
  `CHK_NEXT(a_accept_leaves_idle, clk, rst, start && !busy && (items_stored < CW'(MAX_ITEMS) || is_last), busy)
endmodule
